### sv/dcon_pkg.sv
`default_nettype none
package dcon_pkg;

    // longest frame the byte counter follows before it saturates
    localparam int MAX_FRAME_DEF = 255;

    // frame layout
    localparam int SUM_BYTES    = 5;   // bytes 0..4 enter the checksum
    localparam int DIGIT_FIRST  = 1;   // first hex digit position
    localparam int DIGIT_LAST   = 4;   // last hex digit position
    localparam int MIN_LAST_IDX = 7;   // index of final byte in shortest good frame

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_REPORT_EN  = 2'd0;
    localparam logic [1:0] REG_CMP_WORDS  = 2'd1;
    localparam logic [1:0] REG_RETRY_LOAD = 2'd2;

    // reset values
    localparam logic       REPORT_EN_RST  = 1'b1;
    localparam logic       CMP_WORDS_RST  = 1'b1;
    localparam logic [3:0] RETRY_LOAD_RST = 4'd3;
    localparam logic [3:0] RETRIES_RST    = 4'd3;

    // frame result queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // judged frame, front to back
    typedef struct packed {
        logic        ok;
        logic [15:0] value;
    } t_frame_res;

    // head of the queue as the back end sees it
    typedef struct packed {
        logic       valid;
        t_frame_res data;
    } t_q_head;

    // configuration registers
    typedef struct packed {
        logic       report_enable;
        logic       compared_words;
        logic [3:0] retry_reload;
    } t_cfg;

    // ASCII hex digit (0-9, A-F) to nibble; anything else, lowercase a-f included, gives zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(8'h0A + (c - 8'h41));
        end
        return v;
    endfunction

    // nibble to uppercase ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'd0, n};
        end else begin
            c = 8'h41 + ({4'd0, n} - 8'h0A);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### sv/dcon_front.sv
`default_nettype none
module dcon_front #(
    parameter int MAX_FRAME = dcon_pkg::MAX_FRAME_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic                 i_last_byte,
    input  wire logic                 i_q_full,
    output logic                      o_in_stall,
    output logic                      o_push,
    output dcon_pkg::t_frame_res      o_push_data
);
    import dcon_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic [15:0]      r_digit, n_digit;
    logic [15:0]      r_tail, n_tail;   // the two bytes before the current one

    logic accept;
    logic too_long;
    logic ok;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid & ~i_q_full;
    assign too_long   = r_count >= CNT_W'(MAX_FRAME);

    // frame check on the final byte: length, then both checksum characters
    assign ok = ~too_long && (r_count >= CNT_W'(MIN_LAST_IDX)) &&
                (r_tail[15:8] == hex_char(r_sum[7:4])) &&
                (r_tail[7:0]  == hex_char(r_sum[3:0]));

    assign o_push            = accept & i_last_byte;
    assign o_push_data.ok    = ok;
    assign o_push_data.value = r_digit;

    // accumulators for the frame in flight
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_digit = r_digit;
        n_tail  = r_tail;
        if (accept) begin
            if (~too_long) begin
                if (r_count < CNT_W'(SUM_BYTES)) begin
                    n_sum = r_sum + i_rx_byte;
                end
                if (r_count >= CNT_W'(DIGIT_FIRST) && r_count <= CNT_W'(DIGIT_LAST)) begin
                    n_digit = {r_digit[11:0], hex_value(i_rx_byte)};
                end
            end
            if (i_last_byte) begin
                n_count = '0;
                n_sum   = '0;
                n_digit = '0;
                n_tail  = '0;
            end else begin
                n_tail = {r_tail[7:0], i_rx_byte};
                if (~too_long) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_digit <= '0;
            r_tail  <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_digit <= n_digit;
            r_tail  <= n_tail;
        end
    end

endmodule
`default_nettype wire

### sv/dcon_queue.sv
`default_nettype none
module dcon_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  dcon_pkg::t_frame_res      i_push_data,
    input  wire logic                 i_pop,
    output logic                      o_full,
    output dcon_pkg::t_q_head         o_head
);
    import dcon_pkg::*;

    t_frame_res        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full      = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_head.valid = r_cnt != '0;
    assign o_head.data  = r_mem[r_rd_ptr];

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_head.valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push & ~do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop & ~do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### sv/dcon_back.sv
`default_nettype none
module dcon_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  dcon_pkg::t_q_head    i_head,
    input  dcon_pkg::t_cfg       i_cfg,
    input  wire logic            i_out_stall,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output logic                 o_frame_ok,
    output logic                 o_link_valid,
    output logic                 o_validity_toggled,
    output logic [15:0]          o_value,
    output logic [15:0]          o_change_mask,
    output logic                 o_report_change
);
    import dcon_pkg::*;

    // link state
    logic [15:0] r_stored, n_stored;
    logic        r_valid_flag, n_valid_flag;
    logic [3:0]  r_retries, n_retries;
    logic        r_awaiting, n_awaiting;

    // result word
    logic        r_out_valid;
    logic        r_frame_ok;
    logic        r_link_valid;
    logic        r_toggled;
    logic [15:0] r_value;
    logic [15:0] r_mask;
    logic        r_report;

    logic [15:0] mask;
    logic        report;

    assign o_pop = i_head.valid & (~r_out_valid | ~i_out_stall);

    // link state update for the frame at the queue head
    always_comb begin
        n_stored     = r_stored;
        n_valid_flag = r_valid_flag;
        n_retries    = r_retries;
        n_awaiting   = r_awaiting;
        mask         = '0;
        if (i_head.data.ok) begin
            n_stored     = i_head.data.value;
            n_valid_flag = 1'b1;
            n_retries    = i_cfg.retry_reload;
            n_awaiting   = 1'b0;
            if (~r_awaiting & i_cfg.report_enable & i_cfg.compared_words) begin
                mask = r_stored ^ i_head.data.value;
            end
        end else if (r_retries == '0) begin
            n_valid_flag = 1'b0;
        end else begin
            n_retries = r_retries - 4'd1;
        end
        report = mask != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored     <= '0;
            r_valid_flag <= 1'b0;
            r_retries    <= RETRIES_RST;
            r_awaiting   <= 1'b1;
        end else if (o_pop) begin
            r_stored     <= n_stored;
            r_valid_flag <= n_valid_flag;
            r_retries    <= n_retries;
            r_awaiting   <= n_awaiting;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (~i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame_ok   <= i_head.data.ok;
            r_link_valid <= n_valid_flag;
            r_toggled    <= n_valid_flag ^ r_valid_flag;
            r_value      <= n_stored;
            r_mask       <= mask;
            r_report     <= report;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_ok         = r_frame_ok;
    assign o_link_valid       = r_link_valid;
    assign o_validity_toggled = r_toggled;
    assign o_value            = r_value;
    assign o_change_mask      = r_mask;
    assign o_report_change    = r_report;

endmodule
`default_nettype wire

### sv/dcon_response_change_detector.sv
`default_nettype none
// Channel  | Valid        | Stall         | Word
// ---------+--------------+---------------+---------------------------------------------
// in       | i_in_valid   | o_in_stall    | i_rx_byte, i_last_byte
// out      | o_out_valid  | i_out_stall   | o_frame_ok, o_link_valid, o_validity_toggled,
//          |              |               | o_value, o_change_mask, o_report_change
// cfg      | psel/penable | pready (high) | paddr, pwdata, pwrite, prdata
//
// One byte per cycle is taken while the queue is not full; a frame's final byte yields one
// result word, registered in the queue and then in the output register; other bytes yield none.
// A two-entry queue between the byte front end and the link state back end sets how many
// frame results may wait; the input stalls only when it is full.
// Synchronous active-low reset: link invalid, three retries, no good frame seen yet.
module dcon_response_change_detector #(
    parameter int MAX_FRAME = dcon_pkg::MAX_FRAME_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // byte input
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic                          i_last_byte,
    // result output
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_frame_ok,
    output logic                               o_link_valid,
    output logic                               o_validity_toggled,
    output logic [15:0]                        o_value,
    output logic [15:0]                        o_change_mask,
    output logic                               o_report_change,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dcon_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dcon_pkg::DATA_W-1:0]   pwdata,
    output logic [dcon_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import dcon_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic       q_full;
    logic       push;
    logic       pop;
    t_frame_res push_data;
    t_q_head    head;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.report_enable  <= REPORT_EN_RST;
            r_cfg.compared_words <= CMP_WORDS_RST;
            r_cfg.retry_reload   <= RETRY_LOAD_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_REPORT_EN:  r_cfg.report_enable  <= pwdata[0];
                REG_CMP_WORDS:  r_cfg.compared_words <= pwdata[0];
                REG_RETRY_LOAD: r_cfg.retry_reload   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_REPORT_EN:  prdata[0]   = r_cfg.report_enable;
            REG_CMP_WORDS:  prdata[0]   = r_cfg.compared_words;
            REG_RETRY_LOAD: prdata[3:0] = r_cfg.retry_reload;
            default:        prdata      = '0;
        endcase
    end

    dcon_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data)
    );

    dcon_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_head      (head)
    );

    dcon_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head),
        .i_cfg              (r_cfg),
        .i_out_stall        (i_out_stall),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .o_frame_ok         (o_frame_ok),
        .o_link_valid       (o_link_valid),
        .o_validity_toggled (o_validity_toggled),
        .o_value            (o_value),
        .o_change_mask      (o_change_mask),
        .o_report_change    (o_report_change)
    );

endmodule
`default_nettype wire

### dv/tb_dcon_response_change_detector.sv
`default_nettype none
module tb_dcon_response_change_detector;
    import dcon_pkg::*;

    // one judged frame as it leaves the block
    typedef struct packed {
        logic        ok;
        logic        link;
        logic        toggled;
        logic [15:0] value;
        logic [15:0] mask;
        logic        report;
    } t_exp_res;

    // how a frame is put together
    typedef enum {FR_GOOD, FR_BADSUM, FR_RAW, FR_NOISE} t_frame_kind;

    typedef struct {
        t_frame_kind kind;
        int          len;
        logic [15:0] val;
        bit          typed;
        t_exp_res    res;
    } t_frame_row;

    localparam int PHASE_BYTES = 135;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [7:0]          i_rx_byte;
    logic                i_last_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_frame_ok;
    logic                o_link_valid;
    logic                o_validity_toggled;
    logic [15:0]         o_value;
    logic [15:0]         o_change_mask;
    logic                o_report_change;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    dcon_response_change_detector u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_rx_byte          (i_rx_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frame_ok         (o_frame_ok),
        .o_link_valid       (o_link_valid),
        .o_validity_toggled (o_validity_toggled),
        .o_value            (o_value),
        .o_change_mask      (o_change_mask),
        .o_report_change    (o_report_change),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted block state
    t_cfg        cfg_now;
    logic [7:0]  byte_cnt;
    logic [7:0]  csum;
    logic [15:0] digits;
    logic [23:0] tail;
    logic [15:0] stored;
    logic        link_ok;
    logic [3:0]  retries;
    logic        first_pending;

    t_exp_res    exp_q[$];
    t_exp_res    typed_res;
    bit          use_typed;
    logic [7:0]  frame_buf[];
    bit          idling;
    int          stall_left;
    int          mismatches;
    int          sent_bytes;
    int          frames;
    int          good_frames;
    int          link_drops;
    int          reports;
    int          settings;

    // directed frames; typed results only where they follow at a glance
    t_frame_row dir_rows[16] = '{
        '{FR_NOISE,  1,   16'h0000, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0}},
        '{FR_NOISE,  7,   16'h0000, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0}},
        '{FR_GOOD,   8,   16'hFFFF, 1'b1, '{1'b1, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 1'b0}},
        '{FR_GOOD,   8,   16'h0000, 1'b1, '{1'b1, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 1'b1}},
        '{FR_GOOD,   8,   16'h0000, 1'b1, '{1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0}},
        '{FR_BADSUM, 8,   16'h1234, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0}},
        '{FR_RAW,    10,  16'h0000, 1'b0, '0},
        '{FR_GOOD,   255, 16'hA5C3, 1'b0, '0},
        '{FR_GOOD,   256, 16'h5A3C, 1'b0, '0},
        '{FR_GOOD,   9,   16'h1234, 1'b0, '0},
        '{FR_NOISE,  3,   16'h0000, 1'b0, '0},
        '{FR_NOISE,  4,   16'h0000, 1'b0, '0},
        '{FR_NOISE,  5,   16'h0000, 1'b0, '0},
        '{FR_NOISE,  6,   16'h0000, 1'b0, '0},
        '{FR_BADSUM, 8,   16'h0F0F, 1'b0, '0},
        '{FR_GOOD,   12,  16'h8001, 1'b0, '0}
    };

    function automatic logic [3:0] nib_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return 4'(c - 8'h37);
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] ascii_of(logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    // fold one accepted byte into the frame; on the final byte judge it
    function automatic void accept_byte(logic [7:0] b, logic fin);
        t_exp_res   r;
        logic       past_end;
        logic       was_link;
        logic [15:0] old;
        int         len;
        past_end = (byte_cnt >= MAX_FRAME_DEF);
        if (!past_end) begin
            if (byte_cnt < SUM_BYTES) csum = csum + b;
            if (byte_cnt >= DIGIT_FIRST && byte_cnt <= DIGIT_LAST)
                digits = {digits[11:0], nib_of(b)};
        end
        if (!fin) begin
            tail = {tail[15:0], b};
            if (!past_end) byte_cnt = byte_cnt + 8'd1;
        end else begin
            len = int'(byte_cnt) + 1;
            r = '0;
            r.ok = !past_end && len > MIN_LAST_IDX &&
                   tail[15:8] == ascii_of(csum[7:4]) && tail[7:0] == ascii_of(csum[3:0]);
            was_link = link_ok;
            if (r.ok) begin
                old = stored;
                stored = digits;
                link_ok = 1'b1;
                retries = cfg_now.retry_reload;
                if (!first_pending && cfg_now.report_enable && cfg_now.compared_words) begin
                    r.mask = old ^ stored;
                    r.report = (r.mask != 16'd0);
                end
                first_pending = 1'b0;
                good_frames++;
            end else if (retries == 4'd0) begin
                link_ok = 1'b0;
            end else begin
                retries = retries - 4'd1;
            end
            r.link = link_ok;
            r.toggled = (link_ok != was_link);
            r.value = stored;
            if (r.toggled && !link_ok) link_drops++;
            if (r.report) reports++;
            exp_q.push_back(use_typed ? typed_res : r);
            use_typed = 1'b0;
            frames++;
            byte_cnt = '0;
            csum = '0;
            digits = '0;
            tail = '0;
        end
    endfunction

    // layout: start char or not, 4 digits, filler, checksum pair, end char or not
    function automatic void make_frame(t_frame_kind kind, int len, logic [15:0] val);
        logic [7:0] sum;
        frame_buf = new[len];
        foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(0, 255));
        if (kind != FR_NOISE && len >= 8) begin
            if ($urandom_range(0, 1)) frame_buf[0] = 8'h3E;
            for (int d = 1; d <= 4; d++) begin
                if (kind != FR_RAW || $urandom_range(0, 1))
                    frame_buf[d] = ascii_of(val[(4 - d) * 4 +: 4]);
            end
            sum = '0;
            for (int i = 0; i < SUM_BYTES; i++) sum = sum + frame_buf[i];
            frame_buf[len - 3] = ascii_of(sum[7:4]);
            frame_buf[len - 2] = ascii_of(sum[3:0]);
            if (kind == FR_BADSUM)
                frame_buf[len - 3 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            if ($urandom_range(0, 3) != 0) frame_buf[len - 1] = 8'h0D;
        end
    endfunction

    // offer one word on the input; returns at the falling edge after it was taken
    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        gap = (idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte = b;
        i_last_byte = fin;
        do @(posedge i_clk); while (o_in_stall);
        accept_byte(b, fin);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // let the block run dry before touching its registers
    task automatic drain();
        i_in_valid = 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data, logic [31:0] keep);
        logic [31:0] rd;
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        // read back
        @(negedge i_clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if ((rd & keep) !== (data & keep)) begin
            $error("register %0d readback: expected %0h, got %0h", idx, data & keep, rd & keep);
            mismatches++;
        end
    endtask

    task automatic set_config(logic re, logic cw, logic [3:0] rl);
        drain();
        write_reg(REG_REPORT_EN, {31'd0, re}, 32'h1);
        write_reg(REG_CMP_WORDS, {31'd0, cw}, 32'h1);
        write_reg(REG_RETRY_LOAD, {28'd0, rl}, 32'hF);
        cfg_now.report_enable = re;
        cfg_now.compared_words = cw;
        cfg_now.retry_reload = rl;
        settings++;
    endtask

    // one random frame, mostly well formed; now and then a run of bad ones
    task automatic random_frame();
        int          pick;
        int          len;
        logic [15:0] v;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(8, 12);
        case ($urandom_range(0, 3))
            0: v = stored;
            1: v = stored ^ (16'h1 << $urandom_range(0, 15));
            default: v = 16'($urandom);
        endcase
        if (pick < 55) begin
            make_frame(FR_GOOD, len, v);
            send_frame();
        end else if (pick < 67) begin
            make_frame(FR_BADSUM, len, v);
            send_frame();
        end else if (pick < 77) begin
            make_frame(FR_RAW, len, v);
            send_frame();
        end else if (pick < 85) begin
            make_frame(FR_NOISE, $urandom_range(1, 7), v);
            send_frame();
        end else if (pick < 90) begin
            make_frame(FR_NOISE, $urandom_range(8, 20), v);
            send_frame();
        end else begin
            for (int n = 0; n < int'(cfg_now.retry_reload) + 2; n++) begin
                make_frame(FR_NOISE, $urandom_range(1, 7), v);
                send_frame();
            end
        end
    endtask

    // receiver back-pressure in short bursts
    always @(negedge i_clk) begin
        if (!idling) begin
            i_out_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall = 1'b1;
        end else if ($urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // compare every result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_exp_res want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (exp_q.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = exp_q.pop_front();
                check_field("frame_ok", want.ok, o_frame_ok);
                check_field("link_valid", want.link, o_link_valid);
                check_field("validity_toggled", want.toggled, o_validity_toggled);
                check_field("value", want.value, o_value);
                check_field("change_mask", want.mask, o_change_mask);
                check_field("report_change", want.report, o_report_change);
            end
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte = '0;
        i_last_byte = 1'b0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idling = 1'b1;
        stall_left = 0;
        use_typed = 1'b0;
        cfg_now.report_enable = REPORT_EN_RST;
        cfg_now.compared_words = CMP_WORDS_RST;
        cfg_now.retry_reload = RETRY_LOAD_RST;
        byte_cnt = '0;
        csum = '0;
        digits = '0;
        tail = '0;
        stored = '0;
        link_ok = 1'b0;
        retries = RETRIES_RST;
        first_pending = 1'b1;
        settings = 1;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed frames on reset settings
        foreach (dir_rows[k]) begin
            use_typed = dir_rows[k].typed;
            typed_res = dir_rows[k].res;
            make_frame(dir_rows[k].kind, dir_rows[k].len, dir_rows[k].val);
            send_frame();
        end

        // random traffic across several register settings, quiet at the end
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(1'b1, 1'b1, 4'd0);
                1: set_config(1'b0, 1'b1, 4'd15);
                2: set_config(1'b1, 1'b0, 4'd7);
                3: set_config(1'b0, 1'b0, 4'd1);
                4: set_config(1'b1, 1'b1, 4'd15);
                default: begin
                    set_config(1'b1, 1'b1, 4'd3);
                    idling = 1'b0;
                end
            endcase
            sent_bytes = 0;
            while (sent_bytes < PHASE_BYTES) random_frame();
        end

        i_in_valid = 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d frames over %0d register settings: %0d good, %0d link losses,",
                 frames, settings, good_frames, link_drops);
        $display("and %0d change reports, with random gaps and back-pressure on both sides.",
                 reports);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
sv/dcon_pkg.sv
sv/dcon_front.sv
sv/dcon_queue.sv
sv/dcon_back.sv
sv/dcon_response_change_detector.sv
dv/tb_dcon_response_change_detector.sv
